// File: sv/battery_charge_test_monitor_assert.svh
// assertion macros used by the battery charge test monitor
`ifndef BATTERY_CHARGE_TEST_MONITOR_ASSERT_SVH
`define BATTERY_CHARGE_TEST_MONITOR_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define BCTM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bctm assertion failed");

// next-cycle implication, disabled while reset is asserted
`define BCTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bctm assertion failed");

`endif

// File: sv/bctm_pkg.sv
// types, constants and the window accumulate function of the battery test monitor
package bctm_pkg;

  localparam int unsigned BatteriesDef = 5;
  localparam int unsigned SamplesDef   = 50;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned BatW    = 3;
  localparam int unsigned SampleW = 10;
  localparam int unsigned SumW    = 16;
  localparam int unsigned CntW    = 6;
  localparam int unsigned LimW    = 16;
  localparam int unsigned EvW     = 3;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;

  // reset values of the limit registers (sums of 50 converter counts)
  localparam logic [LimW-1:0] ConnectLimDef   = 16'd17709;
  localparam logic [LimW-1:0] HotLimDef       = 16'd6250;
  localparam logic [LimW-1:0] DischargeLimDef = 16'd20833;
  localparam logic [LimW-1:0] FullLimDef      = 16'd43750;

  // register indexes
  localparam logic [1:0] RegConnect   = 2'd0;
  localparam logic [1:0] RegHot       = 2'd1;
  localparam logic [1:0] RegDischarge = 2'd2;
  localparam logic [1:0] RegFull      = 2'd3;

  // check slots within a battery row
  localparam int unsigned CkNum  = 5;
  localparam int unsigned CkConn = 0;
  localparam int unsigned CkNeed = 1;
  localparam int unsigned CkFull = 2;
  localparam int unsigned CkHot  = 3;
  localparam int unsigned CkDlim = 4;

  typedef enum logic [FuncW-1:0] {
    FUNC_TICK = 2'd0,
    FUNC_CHG  = 2'd1,
    FUNC_DCHG = 2'd2,
    FUNC_END  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    MODE_DISC   = 3'd0,
    MODE_CHG    = 3'd1,
    MODE_DCHG   = 3'd2,
    MODE_RESULT = 3'd3,
    MODE_CHECK  = 3'd4,
    MODE_CONN   = 3'd5
  } mode_e;

  typedef enum logic [EvW-1:0] {
    EV_CONNECTED    = 3'd0,
    EV_DISCONNECTED = 3'd1,
    EV_NEED_CHARGE  = 3'd2,
    EV_NEED_DISCH   = 3'd3,
    EV_FULL         = 3'd4,
    EV_HOT          = 3'd5,
    EV_DLIM         = 3'd6
  } ev_e;

  typedef enum logic {
    KIND_EVENT = 1'b0,
    KIND_CTRL  = 1'b1
  } kind_e;

  // control line codes, bit 0 charge, bit 1 discharge
  localparam logic [1:0] LinesOff  = 2'b00;
  localparam logic [1:0] LinesChg  = 2'b01;
  localparam logic [1:0] LinesDchg = 2'b10;

  typedef struct packed {
    logic [SumW-1:0] sum;
    logic [CntW-1:0] cnt;
  } ck_t;

  // one battery's whole state, one memory row
  typedef struct packed {
    mode_e             mode;
    logic              flag;
    logic [1:0]        lines;
    ck_t [CkNum-1:0]   ck;
  } row_t;

  typedef struct packed {
    ck_t             ck;
    logic            done;
    logic [SumW-1:0] win;
  } acc_t;

  // add one sample to a window; on completion give the sum and restart
  function automatic acc_t acc_step(ck_t c, logic [SampleW-1:0] s, logic [CntW-1:0] samples);
    acc_t r;
    r.ck.sum = c.sum + SumW'(s);
    r.ck.cnt = c.cnt + CntW'(1);
    r.done   = (r.ck.cnt >= samples);
    r.win    = r.ck.sum;
    if (r.done) begin
      r.ck = '0;
    end
    return r;
  endfunction

endpackage

// File: sv/bctm_ram.sv
// generic single-write, single-read RAM with registered read data
module bctm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/battery_charge_test_monitor.sv
// battery charge test monitor top level: per-battery row RAM with read-modify-write
// flow: an accepted transaction is computed in the compute stage and its results are
//   registered in the result group stage, which offers them on the result port
// throughput: one input transaction per cycle while each gives at most one result and
//   the result port is ready; several results of one item go out one at a time
// reset: control and limit registers reset at once; per-battery valid bits make
//   unwritten rows read as zero, so there is no memory clearing pass
`include "battery_charge_test_monitor_assert.svh"

module battery_charge_test_monitor #(
  parameter int unsigned BATTERIES = bctm_pkg::BatteriesDef,
  parameter int unsigned SAMPLES   = bctm_pkg::SamplesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bctm_pkg::FuncW-1:0]    func_i,
  input  logic [bctm_pkg::BatW-1:0]     battery_i,
  input  logic [bctm_pkg::SampleW-1:0]  voltage_sample_i,
  input  logic [bctm_pkg::SampleW-1:0]  temperature_sample_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bctm_pkg::BatW-1:0]     battery_out_o,
  output logic                          result_kind_o,
  output logic [bctm_pkg::EvW-1:0]      event_code_o,
  output logic                          ctrl_charge_o,
  output logic                          ctrl_discharge_o,
  output logic                          all_disconnected_o,
  output logic                          last_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bctm_pkg::AddrW-1:0]    paddr,
  input  logic [bctm_pkg::DataW-1:0]    pwdata,
  output logic [bctm_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  import bctm_pkg::*;

  // battery address width and a wider index for the range check
  localparam int unsigned AW = (BATTERIES > 1) ? $clog2(BATTERIES) : 1;
  localparam int unsigned IW = ((AW > BatW) ? AW : BatW) + 1;
  localparam int unsigned RowW = $bits(row_t);
  localparam logic [CntW-1:0] SampCnt = CntW'(SAMPLES);
  localparam logic [IW-1:0] BatLim = IW'(BATTERIES);

  // ---------------------------------------------------------------------------
  // limit registers
  // ---------------------------------------------------------------------------
  logic [LimW-1:0] connect_lim_q, hot_lim_q, dlim_lim_q, full_lim_q;
  logic            cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      connect_lim_q <= ConnectLimDef;
      hot_lim_q     <= HotLimDef;
      dlim_lim_q    <= DischargeLimDef;
      full_lim_q    <= FullLimDef;
    end else if (cfg_we) begin
      case (paddr[3:2])
        RegConnect:   connect_lim_q <= pwdata[LimW-1:0];
        RegHot:       hot_lim_q     <= pwdata[LimW-1:0];
        RegDischarge: dlim_lim_q    <= pwdata[LimW-1:0];
        RegFull:      full_lim_q    <= pwdata[LimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegConnect:   prdata = DataW'(connect_lim_q);
      RegHot:       prdata = DataW'(hot_lim_q);
      RegDischarge: prdata = DataW'(dlim_lim_q);
      RegFull:      prdata = DataW'(full_lim_q);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // accept stage: issue the row read
  // ---------------------------------------------------------------------------
  logic [IW-1:0] in_bat_ext;
  logic [AW-1:0] in_addr;
  logic          in_bat_ok;
  logic          in_acc;

  assign in_bat_ext = IW'(battery_i);
  assign in_addr    = in_bat_ext[AW-1:0];
  assign in_bat_ok  = (in_bat_ext < BatLim);
  assign in_acc     = in_valid_i & in_ready_o;

  // ---------------------------------------------------------------------------
  // compute stage registers
  // ---------------------------------------------------------------------------
  logic                s1_valid_q;
  func_e               s1_func_q;
  logic [BatW-1:0]     s1_bat_q;
  logic [AW-1:0]       s1_addr_q;
  logic                s1_bat_ok_q;
  logic [SampleW-1:0]  s1_volt_q, s1_temp_q;
  logic                rd_vld_q;     // row had been written when it was read
  logic                fwd_hit_q;    // row was written on the edge it was read
  row_t                fwd_row_q;
  logic [BATTERIES-1:0] valid_q;     // row written since reset
  logic [BATTERIES-1:0] disc_q;      // battery in disconnected mode
  logic [RowW-1:0]     ram_rdata;

  logic                s1_adv;
  logic                s1_we;

  // result group stage
  logic                grp_valid_q;
  ev_e                 grp_code_q [3];
  logic [1:0]          grp_n_q;
  logic [1:0]          grp_idx_q;
  logic [BatW-1:0]     grp_bat_q;
  kind_e               grp_kind_q;
  logic [1:0]          grp_lines_q;
  logic                grp_alld_q;
  logic                grp_last;
  logic                grp_done;

  // ---------------------------------------------------------------------------
  // battery row update
  // ---------------------------------------------------------------------------
  row_t                cur, nxt;
  acc_t                a;
  ev_e                 codes [3];
  logic [1:0]          n;
  kind_e               kind;
  logic                run;
  logic [BATTERIES-1:0] disc_new;
  logic                alld;

  always_comb begin
    // current row: forwarded, stored, or the reset value
    if (fwd_hit_q) begin
      cur = fwd_row_q;
    end else if (rd_vld_q) begin
      cur = row_t'(ram_rdata);
    end else begin
      cur = '0;
    end
    nxt   = cur;
    a     = '0;
    n     = 2'd0;
    kind  = KIND_EVENT;
    run   = 1'b0;
    for (int k = 0; k < 3; k++) begin
      codes[k] = EV_CONNECTED;
    end

    if (s1_func_q == FUNC_TICK) begin
      run = cur.mode inside {MODE_DISC, MODE_CONN, MODE_CHECK, MODE_CHG, MODE_DCHG};
      // connection check on the temperature pin
      if (run) begin
        a = acc_step(cur.ck[CkConn], s1_temp_q, SampCnt);
        nxt.ck[CkConn] = a.ck;
        if (a.done) begin
          if (a.win < connect_lim_q) begin
            codes[n] = EV_CONNECTED;
            nxt.flag = 1'b1;
          end else begin
            codes[n] = EV_DISCONNECTED;
            nxt.flag = 1'b0;
          end
          n = n + 2'd1;
        end
      end
      case (cur.mode)
        MODE_DISC: begin
          if (nxt.flag) begin
            nxt.mode = MODE_CONN;
          end
        end
        MODE_CONN: begin
          nxt.mode = nxt.flag ? MODE_CHECK : MODE_DISC;
        end
        MODE_CHECK: begin
          a = acc_step(cur.ck[CkNeed], s1_volt_q, SampCnt);
          nxt.ck[CkNeed] = a.ck;
          if (a.done) begin
            codes[n] = (a.win < full_lim_q) ? EV_NEED_CHARGE : EV_NEED_DISCH;
            n = n + 2'd1;
          end
        end
        MODE_CHG: begin
          a = acc_step(cur.ck[CkFull], s1_volt_q, SampCnt);
          nxt.ck[CkFull] = a.ck;
          if (a.done && (a.win >= full_lim_q)) begin
            codes[n] = EV_FULL;
            n = n + 2'd1;
          end
        end
        MODE_DCHG: begin
          a = acc_step(cur.ck[CkDlim], s1_volt_q, SampCnt);
          nxt.ck[CkDlim] = a.ck;
          if (a.done && (a.win <= dlim_lim_q)) begin
            codes[n] = EV_DLIM;
            n = n + 2'd1;
          end
        end
        default: ;
      endcase
      // hot check, one window shared by charging and discharging
      if (cur.mode == MODE_CHG || cur.mode == MODE_DCHG) begin
        a = acc_step(cur.ck[CkHot], s1_temp_q, SampCnt);
        nxt.ck[CkHot] = a.ck;
        if (a.done && (a.win <= hot_lim_q)) begin
          codes[n] = EV_HOT;
          n = n + 2'd1;
        end
      end
    end else begin
      // commands set mode and control lines, one control update each
      case (s1_func_q)
        FUNC_CHG: begin
          nxt.mode  = MODE_CHG;
          nxt.lines = LinesChg;
        end
        FUNC_DCHG: begin
          nxt.mode  = MODE_DCHG;
          nxt.lines = LinesDchg;
        end
        default: begin
          nxt.mode  = MODE_DISC;
          nxt.lines = LinesOff;
        end
      endcase
      codes[0] = EV_CONNECTED;
      n        = 2'd1;
      kind     = KIND_CTRL;
    end

    // out-of-range battery: item dropped
    if (!s1_bat_ok_q) begin
      n = 2'd0;
    end

    disc_new = disc_q;
    if (s1_bat_ok_q) begin
      disc_new[s1_addr_q] = (nxt.mode == MODE_DISC);
    end
    alld = &disc_new;
  end

  // compute stage moves on when its results fit in the group stage
  assign grp_last   = (grp_idx_q == (grp_n_q - 2'd1));
  assign grp_done   = grp_valid_q & out_ready_i & grp_last;
  assign s1_adv     = s1_valid_q & ((n == 2'd0) | ~grp_valid_q | grp_done);
  assign s1_we      = s1_adv & s1_bat_ok_q;
  assign in_ready_o = ~s1_valid_q | s1_adv;

  bctm_ram #(
    .Width (RowW),
    .Depth (BATTERIES)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (s1_we),
    .waddr_i (s1_addr_q),
    .wdata_i (RowW'(nxt)),
    .re_i    (in_acc & in_bat_ok),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  // compute stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
      rd_vld_q   <= 1'b0;
      valid_q    <= '0;
      disc_q     <= '1;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        rd_vld_q   <= in_bat_ok & valid_q[in_addr];
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (in_acc || s1_adv) begin
        // the RAM returns the old row when it is written on the edge it is read
        fwd_hit_q <= in_acc & s1_we & (in_addr == s1_addr_q);
      end
      if (s1_we) begin
        valid_q[s1_addr_q] <= 1'b1;
        disc_q             <= disc_new;
      end
    end
  end

  // compute stage payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_func_q   <= func_e'(func_i);
      s1_bat_q    <= battery_i;
      s1_addr_q   <= in_addr;
      s1_bat_ok_q <= in_bat_ok;
      s1_volt_q   <= voltage_sample_i;
      s1_temp_q   <= temperature_sample_i;
    end
    if (s1_we) begin
      fwd_row_q <= nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // result group: sends up to three results, one per transaction
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_valid_q <= 1'b0;
      grp_idx_q   <= 2'd0;
    end else if (s1_adv && (n != 2'd0)) begin
      grp_valid_q <= 1'b1;
      grp_idx_q   <= 2'd0;
    end else if (grp_done) begin
      grp_valid_q <= 1'b0;
    end else if (grp_valid_q && out_ready_i) begin
      grp_idx_q <= grp_idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && (n != 2'd0)) begin
      grp_code_q  <= codes;
      grp_n_q     <= n;
      grp_bat_q   <= s1_bat_q;
      grp_kind_q  <= kind;
      grp_lines_q <= nxt.lines;
      grp_alld_q  <= alld;
    end
  end

  assign out_valid_o        = grp_valid_q;
  assign battery_out_o      = grp_bat_q;
  assign result_kind_o      = grp_kind_q;
  assign event_code_o       = grp_code_q[grp_idx_q];
  assign ctrl_charge_o      = grp_lines_q[0];
  assign ctrl_discharge_o   = grp_lines_q[1];
  assign all_disconnected_o = grp_alld_q;
  assign last_o             = grp_last;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // the result index stays inside the group
  `BCTM_ASSERT_NOW(a_idx_in_group, clk_i, rst_ni, grp_valid_q, grp_idx_q < grp_n_q)
  // input back-pressure only when both stages are full
  `BCTM_ASSERT_NOW(a_ready_backpressure, clk_i, rst_ni, !in_ready_o,
                   s1_valid_q && grp_valid_q)
  // a forward hit always belongs to a waiting item
  `BCTM_ASSERT_NOW(a_fwd_with_item, clk_i, rst_ni, fwd_hit_q, s1_valid_q)
  // an active control line means not all batteries are disconnected
  `BCTM_ASSERT_NOW(a_lines_vs_alld, clk_i, rst_ni,
                   out_valid_o && (ctrl_charge_o || ctrl_discharge_o),
                   !all_disconnected_o)

endmodule

// File: tb/battery_charge_test_monitor_checker.sv
// checker for the battery charge test monitor: predicts results and compares them
module battery_charge_test_monitor_checker #(
  parameter int unsigned BATTERIES = bctm_pkg::BatteriesDef,
  parameter int unsigned SAMPLES   = bctm_pkg::SamplesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [bctm_pkg::FuncW-1:0]    func_i,
  input  logic [bctm_pkg::BatW-1:0]     battery_i,
  input  logic [bctm_pkg::SampleW-1:0]  voltage_sample_i,
  input  logic [bctm_pkg::SampleW-1:0]  temperature_sample_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [bctm_pkg::BatW-1:0]     battery_out_i,
  input  logic                          result_kind_i,
  input  logic [bctm_pkg::EvW-1:0]      event_code_i,
  input  logic                          ctrl_charge_i,
  input  logic                          ctrl_discharge_i,
  input  logic                          all_disconnected_i,
  input  logic                          last_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [bctm_pkg::AddrW-1:0]    paddr_i,
  input  logic [bctm_pkg::DataW-1:0]    pwdata_i,
  input  logic                          pready_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import bctm_pkg::*;

  localparam int MaxReports = 10;

  typedef struct packed {
    logic [BatW-1:0] battery;
    kind_e           kind;
    ev_e             code;
    logic            charge;
    logic            discharge;
    logic            all_disc;
    logic            last;
  } report_t;

  mode_e           bat_mode  [BATTERIES];
  logic            link_flag [BATTERIES];
  logic [1:0]      line_q    [BATTERIES];
  logic [SumW-1:0] win_sum   [BATTERIES][CkNum];
  logic [CntW-1:0] win_cnt   [BATTERIES][CkNum];
  logic [LimW-1:0] lim_connect, lim_hot, lim_dlim, lim_full;
  report_t         reports_q [$];

  // one sample into a check window; returns 1 with the window sum when it closes
  function automatic logic add_to_window(int unsigned b, int unsigned ck,
                                         logic [SampleW-1:0] s,
                                         output logic [SumW-1:0] total);
    logic [SumW-1:0] sum_n;
    logic [CntW-1:0] cnt_n;
    sum_n = win_sum[b][ck] + SumW'(s);
    cnt_n = win_cnt[b][ck] + CntW'(1);
    total = sum_n;
    if (cnt_n >= CntW'(SAMPLES)) begin
      win_sum[b][ck] = '0;
      win_cnt[b][ck] = '0;
      return 1'b1;
    end
    win_sum[b][ck] = sum_n;
    win_cnt[b][ck] = cnt_n;
    return 1'b0;
  endfunction

  task automatic write_limit(logic [AddrW-1:0] addr, logic [DataW-1:0] data);
    case (addr[AddrW-1:2])
      RegConnect:   lim_connect = data[LimW-1:0];
      RegHot:       lim_hot     = data[LimW-1:0];
      RegDischarge: lim_dlim    = data[LimW-1:0];
      RegFull:      lim_full    = data[LimW-1:0];
      default: ;
    endcase
  endtask

  task automatic forecast_results(logic [FuncW-1:0] fn, logic [BatW-1:0] bat,
                                  logic [SampleW-1:0] volt, logic [SampleW-1:0] temp);
    ev_e             codes [$];
    kind_e           kind;
    mode_e           m;
    logic [SumW-1:0] total;
    logic            every_disc;
    report_t         rep;
    int unsigned     b;
    int              i;
    b = 32'(bat);
    if (b >= BATTERIES) return;
    kind = KIND_EVENT;
    if (func_e'(fn) == FUNC_TICK) begin
      m = bat_mode[b];
      if (m inside {MODE_DISC, MODE_CONN, MODE_CHECK, MODE_CHG, MODE_DCHG}) begin
        if (add_to_window(b, CkConn, temp, total)) begin
          link_flag[b] = (total < lim_connect);
          codes.push_back(link_flag[b] ? EV_CONNECTED : EV_DISCONNECTED);
        end
      end
      case (m)
        MODE_DISC: begin
          if (link_flag[b]) bat_mode[b] = MODE_CONN;
        end
        MODE_CONN: begin
          bat_mode[b] = link_flag[b] ? MODE_CHECK : MODE_DISC;
        end
        MODE_CHECK: begin
          if (add_to_window(b, CkNeed, volt, total))
            codes.push_back((total < lim_full) ? EV_NEED_CHARGE : EV_NEED_DISCH);
        end
        MODE_CHG, MODE_DCHG: begin
          if (m == MODE_CHG) begin
            if (add_to_window(b, CkFull, volt, total) && total >= lim_full)
              codes.push_back(EV_FULL);
          end else begin
            if (add_to_window(b, CkDlim, volt, total) && total <= lim_dlim)
              codes.push_back(EV_DLIM);
          end
          // hot window is shared between charging and discharging
          if (add_to_window(b, CkHot, temp, total) && total <= lim_hot)
            codes.push_back(EV_HOT);
        end
        default: ;
      endcase
    end else begin
      case (func_e'(fn))
        FUNC_CHG: begin
          bat_mode[b] = MODE_CHG;
          line_q[b]   = LinesChg;
        end
        FUNC_DCHG: begin
          bat_mode[b] = MODE_DCHG;
          line_q[b]   = LinesDchg;
        end
        default: begin
          bat_mode[b] = MODE_DISC;
          line_q[b]   = LinesOff;
        end
      endcase
      // code field reads zero on a control update
      codes.push_back(EV_CONNECTED);
      kind = KIND_CTRL;
    end
    every_disc = 1'b1;
    for (i = 0; i < BATTERIES; i++)
      if (bat_mode[i] != MODE_DISC) every_disc = 1'b0;
    for (i = 0; i < codes.size(); i++) begin
      rep.battery   = bat;
      rep.kind      = kind;
      rep.code      = codes[i];
      rep.charge    = line_q[b][0];
      rep.discharge = line_q[b][1];
      rep.all_disc  = every_disc;
      rep.last      = (i == codes.size() - 1);
      reports_q.push_back(rep);
    end
  endtask

  task automatic compare_result();
    report_t want;
    if (reports_q.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= MaxReports)
        $display("unexpected result: battery %0d kind %0d event %0d",
                 battery_out_i, result_kind_i, event_code_i);
      return;
    end
    want = reports_q.pop_front();
    if (battery_out_i !== want.battery || result_kind_i !== want.kind ||
        event_code_i !== want.code || ctrl_charge_i !== want.charge ||
        ctrl_discharge_i !== want.discharge || all_disconnected_i !== want.all_disc ||
        last_i !== want.last) begin
      fail_count_o++;
      if (fail_count_o <= MaxReports) begin
        $display("mismatch exp: bat %0d kind %0d ev %0d chg %b dchg %b alldisc %b last %b",
                 want.battery, want.kind, want.code, want.charge, want.discharge,
                 want.all_disc, want.last);
        $display("         got: bat %0d kind %0d ev %0d chg %b dchg %b alldisc %b last %b",
                 battery_out_i, result_kind_i, event_code_i, ctrl_charge_i,
                 ctrl_discharge_i, all_disconnected_i, last_i);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < BATTERIES; b++) begin
        bat_mode[b]  = MODE_DISC;
        link_flag[b] = 1'b0;
        line_q[b]    = LinesOff;
        for (int c = 0; c < CkNum; c++) begin
          win_sum[b][c] = '0;
          win_cnt[b][c] = '0;
        end
      end
      lim_connect = ConnectLimDef;
      lim_hot     = HotLimDef;
      lim_dlim    = DischargeLimDef;
      lim_full    = FullLimDef;
      reports_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) write_limit(paddr_i, pwdata_i);
      if (in_valid_i && in_ready_i)
        forecast_results(func_i, battery_i, voltage_sample_i, temperature_sample_i);
      if (out_valid_i && out_ready_i) compare_result();
      pending_o = reports_q.size();
    end
  end

endmodule

// File: tb/battery_charge_test_monitor_tb.sv
// top of the battery charge test monitor testbench: stimulus, stalls and verdict
module battery_charge_test_monitor_tb;
  import bctm_pkg::*;

  // quiet cycles allowed before the run is declared hung; covers the longest
  // sender gap, the longest result stall and the idle time around register writes
  localparam int WatchdogLimit = 4000;
  // cycles to let a tick that gives no result drain through the pipeline
  localparam int DrainCycles   = 8;
  // accepted items per configuration phase
  localparam int PhaseItems    = 80;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [FuncW-1:0]    func_i;
  logic [BatW-1:0]     battery_i;
  logic [SampleW-1:0]  voltage_sample_i;
  logic [SampleW-1:0]  temperature_sample_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [BatW-1:0]     battery_out_o;
  logic                result_kind_o;
  logic [EvW-1:0]      event_code_o;
  logic                ctrl_charge_o;
  logic                ctrl_discharge_o;
  logic                all_disconnected_o;
  logic                last_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [DataW-1:0]    pwdata;
  logic [DataW-1:0]    prdata;
  logic                pready;

  int fail_count;
  int pending;
  int items_sent;     // accepted items that address a real battery
  int quiet_cycles;

  battery_charge_test_monitor #(
    .BATTERIES (BatteriesDef),
    .SAMPLES   (SamplesDef)
  ) dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .func_i               (func_i),
    .battery_i            (battery_i),
    .voltage_sample_i     (voltage_sample_i),
    .temperature_sample_i (temperature_sample_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .battery_out_o        (battery_out_o),
    .result_kind_o        (result_kind_o),
    .event_code_o         (event_code_o),
    .ctrl_charge_o        (ctrl_charge_o),
    .ctrl_discharge_o     (ctrl_discharge_o),
    .all_disconnected_o   (all_disconnected_o),
    .last_o               (last_o),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  battery_charge_test_monitor_checker #(
    .BATTERIES (BatteriesDef),
    .SAMPLES   (SamplesDef)
  ) checker_i (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_i           (in_ready_o),
    .func_i               (func_i),
    .battery_i            (battery_i),
    .voltage_sample_i     (voltage_sample_i),
    .temperature_sample_i (temperature_sample_i),
    .out_valid_i          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .battery_out_i        (battery_out_o),
    .result_kind_i        (result_kind_o),
    .event_code_i         (event_code_o),
    .ctrl_charge_i        (ctrl_charge_o),
    .ctrl_discharge_i     (ctrl_discharge_o),
    .all_disconnected_i   (all_disconnected_o),
    .last_i               (last_o),
    .psel_i               (psel),
    .penable_i            (penable),
    .pwrite_i             (pwrite),
    .paddr_i              (paddr),
    .pwdata_i             (pwdata),
    .pready_i             (pready),
    .fail_count_o         (fail_count),
    .pending_o            (pending)
  );

  // clock, period 4
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // gap length between transactions: mostly none or short, now and then long
  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // sample value bands: 0 very low (hot, connected, discharge end), 1 very high,
  // 2 anything, 3 moderate (connected but not hot, needs charge)
  function automatic logic [SampleW-1:0] sample_in(int unsigned band);
    case (band)
      0:       return SampleW'($urandom_range(0, 150));
      1:       return SampleW'($urandom_range(880, 1023));
      3:       return SampleW'($urandom_range(200, 300));
      default: return SampleW'($urandom_range(0, 1023));
    endcase
  endfunction

  // drive one input transaction at the falling edge and hold it until accepted
  task automatic send_item(logic [FuncW-1:0] fn, logic [BatW-1:0] bat,
                           logic [SampleW-1:0] volt, logic [SampleW-1:0] temp,
                           logic steady);
    int unsigned gap;
    gap = steady ? 0 : idle_span();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i           = 1'b1;
    func_i               = fn;
    battery_i            = bat;
    voltage_sample_i     = volt;
    temperature_sample_i = temp;
    do @(posedge clk_i); while (!in_ready_o);
    if (bat < BatteriesDef) items_sent++;
  endtask

  // drop valid, wait until every expected result is in, then let the pipe drain
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // register write: setup cycle, then access cycle until pready
  task automatic write_reg(logic [1:0] idx, logic [LimW-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = AddrW'({idx, 2'b00});
    pwdata  = DataW'(value);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apply_limits(logic [LimW-1:0] conn, logic [LimW-1:0] hot,
                              logic [LimW-1:0] dlim, logic [LimW-1:0] full);
    settle();
    write_reg(RegConnect, conn);
    write_reg(RegHot, hot);
    write_reg(RegDischarge, dlim);
    write_reg(RegFull, full);
  endtask

  // one random sequence: mostly a burst of ticks on one battery with biased
  // samples, so the windows close and the modes move; the rest is commands
  // and noise, including items for batteries that do not exist
  task automatic random_sequence(int unsigned budget);
    int unsigned pick, b, len, vband, tband, i;
    logic        steady;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      send_item(FuncW'($urandom_range(0, 3)), BatW'($urandom_range(0, 7)),
                SampleW'($urandom_range(0, 1023)), SampleW'($urandom_range(0, 1023)),
                1'b0);
    end else if (pick <= 2) begin
      send_item(FuncW'($urandom_range(1, 3)), BatW'($urandom_range(0, BatteriesDef - 1)),
                SampleW'($urandom_range(0, 1023)), SampleW'($urandom_range(0, 1023)),
                1'b0);
    end else begin
      b      = $urandom_range(0, BatteriesDef - 1);
      len    = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 160) : $urandom_range(5, 60);
      if (len > budget) len = budget;
      vband  = $urandom_range(0, 3);
      tband  = $urandom_range(0, 3);
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) == 0)
        send_item(FuncW'($urandom_range(1, 3)), BatW'(b), sample_in(2), sample_in(2),
                  steady);
      for (i = 0; i < len; i++) begin
        // now and then a tick for another battery slips in
        if ($urandom_range(0, 9) == 0)
          send_item(FUNC_TICK, BatW'($urandom_range(0, 7)), sample_in(2), sample_in(2),
                    steady);
        else
          send_item(FUNC_TICK, BatW'(b), sample_in(vband), sample_in(tband), steady);
      end
    end
  endtask

  task automatic run_phase();
    int item_base;
    item_base = items_sent;
    while (items_sent - item_base < PhaseItems)
      random_sequence(32'(PhaseItems - (items_sent - item_base)));
  endtask

  // result side stalls: runs of ready with short or long stalls between,
  // and now and then a long stretch with no stall at all
  initial begin
    int unsigned run, stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      run   = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 300) : $urandom_range(1, 40);
      stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
      @(negedge clk_i);
      out_ready_i = 1'b1;
      repeat (run - 1) @(negedge clk_i);
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready_i = 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
    end
  end

  // watchdog: a run with no transaction for too long has hung
  initial quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_ni               = 1'b0;
    in_valid_i           = 1'b0;
    func_i               = FUNC_TICK;
    battery_i            = '0;
    voltage_sample_i     = '0;
    temperature_sample_i = '0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    items_sent           = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    apply_limits(ConnectLimDef, HotLimDef, DischargeLimDef, FullLimDef);

    // directed: sample extremes, items for batteries out of range,
    // every command on battery 0, commands on battery 4, ticks in charging and discharging
    send_item(FUNC_TICK, 3'd0, 10'd0, 10'd0, 1'b1);
    send_item(FUNC_TICK, 3'd4, 10'd1023, 10'd1023, 1'b1);
    send_item(FUNC_TICK, 3'd5, 10'd1023, 10'd0, 1'b0);
    send_item(FUNC_TICK, 3'd6, 10'd0, 10'd1023, 1'b0);
    send_item(FUNC_TICK, 3'd7, 10'd1023, 10'd1023, 1'b0);
    send_item(FUNC_CHG, 3'd7, 10'd0, 10'd0, 1'b0);
    send_item(FUNC_END, 3'd5, 10'd0, 10'd0, 1'b0);
    send_item(FUNC_CHG, 3'd0, 10'd0, 10'd0, 1'b1);
    send_item(FUNC_TICK, 3'd0, 10'd0, 10'd1023, 1'b1);
    send_item(FUNC_DCHG, 3'd0, 10'd0, 10'd0, 1'b1);
    send_item(FUNC_TICK, 3'd0, 10'd1023, 10'd0, 1'b1);
    send_item(FUNC_END, 3'd0, 10'd0, 10'd0, 1'b0);
    send_item(FUNC_CHG, 3'd4, 10'd0, 10'd0, 1'b0);
    send_item(FUNC_END, 3'd4, 10'd0, 10'd0, 1'b0);
    send_item(FUNC_DCHG, 3'd2, 10'd0, 10'd0, 1'b0);
    send_item(FUNC_TICK, 3'd2, 10'd1023, 10'd1023, 1'b0);
    send_item(FUNC_TICK, 3'd2, 10'd0, 10'd0, 1'b0);
    send_item(FUNC_END, 3'd2, 10'd0, 10'd0, 1'b0);
    send_item(FUNC_DCHG, 3'd1, 10'd0, 10'd0, 1'b1);
    send_item(FUNC_CHG, 3'd1, 10'd0, 10'd0, 1'b1);
    send_item(FUNC_END, 3'd1, 10'd0, 10'd0, 1'b1);
    send_item(FUNC_END, 3'd1, 10'd0, 10'd0, 1'b1);

    run_phase();
    // all limits at the bottom: never connected, always full, need discharge
    apply_limits('0, '0, '0, '0);
    run_phase();
    // all limits at the top: always connected, always hot, discharge end at once
    apply_limits('1, '1, '1, '1);
    run_phase();
    apply_limits(LimW'($urandom_range(0, 65535)), LimW'($urandom_range(0, 65535)),
                 LimW'($urandom_range(0, 65535)), LimW'($urandom_range(0, 65535)));
    run_phase();
    apply_limits('1, '0, '1, '0);
    run_phase();
    apply_limits(ConnectLimDef, HotLimDef, DischargeLimDef, FullLimDef);
    run_phase();

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/bctm_pkg.sv
sv/bctm_ram.sv
sv/battery_charge_test_monitor.sv
tb/battery_charge_test_monitor_checker.sv
tb/battery_charge_test_monitor_tb.sv
